@@ src/cwc_pkg.sv @@
package cwc_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 19;

  localparam logic [DAY_W-1:0]   DAYS_PER_WEEK   = 5'd7;
  localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS   = 5'd29;
  localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_MIN        = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEARS_PER_CENT  = 14'd100;
  localparam logic [YEAR_W-1:0]  YEARS_PER_CYCLE = 14'd400;

  // 400-year reduction: subtract 400 << k for k = MOD_STEPS-1 .. 0
  localparam int MOD_STEPS = 5;
  localparam int MOD_K_W   = $clog2(MOD_STEPS);

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] week_count;
    logic               bad_input;
  } out_res_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB && leap) begin
      return LEAP_FEB_DAYS;
    end else if (m >= MONTH_JAN && m <= MONTHS_PER_YEAR) begin
      return MONTH_LEN[idx];
    end else begin
      return MONTH_LEN[0];
    end
  endfunction

endpackage

@@ src/calendar_week_counter.sv @@
// Channel | Ports                          | Moves
// --------+--------------------------------+-------------------------------------
// in      | in_valid, in_ready, in_data    | start and end date request
// out     | out_valid, out_ready, out_data | week count and bad-input flag
//
// Sequence: a request that is out of range or whose end precedes its start goes straight
// to the finish state. Otherwise the year mod-400 reduction runs first, then the week walk adds one
// date step per cycle through a single day/month/year carry unit.
// Reset: rst_n synchronous, clears the sequencer and the output valid.
// Stalls: the result sits in an output register; a new request is taken once the
// sequencer is idle, and a finished count waits only if the previous result is unread.
module calendar_week_counter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cwc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cwc_pkg::out_res_t out_data
);
  import cwc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic [MONTH_W-1:0]   mon_r, mon_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [YEAR_W-1:0]    yrem_r, yrem_nxt;
  logic [MOD_K_W-1:0]   k_r, k_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 bad_r, bad_nxt;
  logic [DAY_W-1:0]     eday_r, eday_nxt;
  logic [MONTH_W-1:0]   emon_r, emon_nxt;
  logic [YEAR_W-1:0]    eyear_r, eyear_nxt;
  out_res_t             out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 in_bad;
  logic                 in_order;
  logic [YEAR_W-1:0]    sub_val;
  logic                 leap;
  logic [DAY_W-1:0]     ml;
  logic [DAY_W:0]       sum;
  logic                 mwrap;
  logic                 ywrap;
  logic [DAY_W-1:0]     next_day;
  logic [MONTH_W-1:0]   next_mon;
  logic [YEAR_W-1:0]    next_year;
  logic [YEAR_W-1:0]    next_yrem;
  logic                 past_end;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_bad = (in_data.start_month < MONTH_JAN) || (in_data.start_month > MONTHS_PER_YEAR) ||
                  (in_data.end_month < MONTH_JAN) || (in_data.end_month > MONTHS_PER_YEAR) ||
                  (in_data.start_year < YEAR_MIN) || (in_data.start_year > YEAR_MAX) ||
                  (in_data.end_year < YEAR_MIN) || (in_data.end_year > YEAR_MAX);
  assign in_order = {in_data.start_year, in_data.start_month, in_data.start_day} >
                    {in_data.end_year, in_data.end_month, in_data.end_day};

  assign sub_val = YEARS_PER_CYCLE << k_r;

  // yrem_r holds year mod 400 once reduced
  assign leap = (year_r[1:0] == 2'b00) && (yrem_r != YEARS_PER_CENT) &&
                (yrem_r != (YEARS_PER_CENT << 1)) &&
                (yrem_r != (YEARS_PER_CYCLE - YEARS_PER_CENT));
  assign ml    = month_days(mon_r, leap);
  assign sum   = {1'b0, day_r} + {1'b0, DAYS_PER_WEEK};
  assign mwrap = sum > {1'b0, ml};
  assign ywrap = mwrap && (mon_r == MONTHS_PER_YEAR);

  always_comb begin
    next_day  = mwrap ? DAY_W'(sum - {1'b0, ml}) : sum[DAY_W-1:0];
    next_mon  = mon_r;
    next_year = year_r;
    next_yrem = yrem_r;
    if (mwrap) begin
      next_mon = (mon_r == MONTHS_PER_YEAR) ? MONTH_JAN : mon_r + MONTH_W'(1);
    end
    if (ywrap) begin
      next_year = year_r + YEAR_W'(1);
      next_yrem = (yrem_r == YEARS_PER_CYCLE - YEAR_W'(1)) ? '0 : yrem_r + YEAR_W'(1);
    end
  end

  assign past_end = {next_year, next_mon, next_day} > {eyear_r, emon_r, eday_r};

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    yrem_nxt      = yrem_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    eday_nxt      = eday_r;
    emon_nxt      = emon_r;
    eyear_nxt     = eyear_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          day_nxt   = in_data.start_day;
          mon_nxt   = in_data.start_month;
          year_nxt  = in_data.start_year;
          yrem_nxt  = in_data.start_year;
          k_nxt     = MOD_K_W'(MOD_STEPS - 1);
          eday_nxt  = in_data.end_day;
          emon_nxt  = in_data.end_month;
          eyear_nxt = in_data.end_year;
          bad_nxt   = in_bad;
          if (in_bad || in_order) begin
            cnt_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            cnt_nxt   = COUNT_W'(1);
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (yrem_r >= sub_val) begin
          yrem_nxt = yrem_r - sub_val;
        end
        k_nxt = k_r - MOD_K_W'(1);
        if (k_r == '0) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (past_end) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt  = cnt_r + COUNT_W'(1);
          day_nxt  = next_day;
          mon_nxt  = next_mon;
          year_nxt = next_year;
          yrem_nxt = next_yrem;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.week_count = cnt_r;
          out_data_nxt.bad_input  = bad_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r      <= day_nxt;
    mon_r      <= mon_nxt;
    year_r     <= year_nxt;
    yrem_r     <= yrem_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    bad_r      <= bad_nxt;
    eday_r     <= eday_nxt;
    emon_r     <= emon_nxt;
    eyear_r    <= eyear_nxt;
    out_data_r <= out_data_nxt;
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_input |-> out_data.week_count == '0)
    else $error("bad request reported a nonzero count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while sequencer busy");

  // the start day is taken as given; every stepped date is a real one
  a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> mon_r >= MONTH_JAN && mon_r <= MONTHS_PER_YEAR &&
                           (cnt_r == COUNT_W'(1) || day_r != '0))
    else $error("week walk reached an impossible date");

  a_walk_yrem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> yrem_r < YEARS_PER_CYCLE)
    else $error("year residue not reduced before the walk");

endmodule

@@ dv/tb_calendar_week_counter.sv @@
module tb_calendar_week_counter;
  import cwc_pkg::*;

  localparam int DIR_N            = 22;
  localparam int UNTYPED          = -1;
  localparam int RANDOM_PER_PHASE = 534;
  localparam int DRAIN_CYCLES     = 20;
  localparam int NUM_PHASES       = 3;

  localparam int unsigned MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // start d/m/y, end d/m/y, week_count, bad_input (UNTYPED: use the predictor)
  localparam int DIRECTED[DIR_N][8] = '{
    '{ 1,  1, 2024,  1,  1,  2024,       1,       0},
    '{ 2,  1, 2024,  1,  1,  2024,       0,       0},
    '{ 1,  0, 2024,  1,  1,  2024,       0,       1},
    '{ 1,  1, 2024,  1, 13,  2024,       0,       1},
    '{ 1, 15, 2024,  1,  1,  2024,       0,       1},
    '{ 1,  1,    0,  1,  1,  2024,       0,       1},
    '{ 1,  1, 2024,  1,  1, 10000,       0,       1},
    '{ 1,  1, 2024,  1,  1, 16383,       0,       1},
    '{ 1,  1, 2024,  8,  1,  2024,       2,       0},
    '{ 1,  1, 2024,  7,  1,  2024,       1,       0},
    '{22,  2, 2024, 31,  3,  2024, UNTYPED, UNTYPED},
    '{22,  2, 1900, 31,  3,  1900, UNTYPED, UNTYPED},
    '{22,  2, 2000, 31,  3,  2000, UNTYPED, UNTYPED},
    '{28, 12, 2023, 10,  1,  2024,       2,       0},
    '{31,  2, 2023, 31,  3,  2023, UNTYPED, UNTYPED},
    '{ 1,  4, 2023, 31,  4,  2023, UNTYPED, UNTYPED},
    '{ 1,  4, 2023,  0,  5,  2023, UNTYPED, UNTYPED},
    '{ 0,  5, 2023,  0,  5,  2023, UNTYPED, UNTYPED},
    '{28, 12, 9999, 31, 12,  9999,       1,       0},
    '{31, 12, 9999,  1,  1,     1,       0,       0},
    '{31, 12, 2023, 31, 12,  2023,       1,       0},
    '{ 1,  1,    1, 31, 12,  9999, UNTYPED, UNTYPED}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 52;
  int          error_count   = 0;
  out_res_t    expected_weeks[$];
  out_res_t    oldest_weeks;

  calendar_week_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return MONTH_DAYS[m - 1];
  endfunction

  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) begin
      n += month_length(y, k);
    end
    return n + d;
  endfunction

  function automatic out_res_t predict_weeks(input in_req_t r);
    out_res_t    res;
    int unsigned sd, sm, sy, ed, em, ey, nd, nm, ny, first_day, last_day, count;
    sd = r.start_day;
    sm = r.start_month;
    sy = r.start_year;
    ed = r.end_day;
    em = r.end_month;
    ey = r.end_year;
    res = '0;
    count = 0;
    res.bad_input = (sm < 1 || sm > 12 || em < 1 || em > 12 ||
                     sy < 1 || sy > 9999 || ey < 1 || ey > 9999);
    if (!res.bad_input &&
        !((sy > ey) || (sy == ey && (sm > em || (sm == em && sd > ed))))) begin
      nd = sd + 7;
      nm = sm;
      ny = sy;
      if (nd > month_length(sy, sm)) begin
        nd -= month_length(sy, sm);
        nm++;
        if (nm > 12) begin
          nm = 1;
          ny++;
        end
      end
      count = 1;
      last_day = day_number((ed > month_length(ey, em)) ? month_length(ey, em) : ed, em, ey);
      first_day = day_number(nd, nm, ny);
      if (first_day <= last_day) begin
        count += (last_day - first_day) / 7 + 1;
      end
    end
    res.week_count = count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic in_req_t make_request(input int unsigned sd, input int unsigned sm,
                                           input int unsigned sy, input int unsigned ed,
                                           input int unsigned em, input int unsigned ey);
    in_req_t r;
    r.start_day   = DAY_W'(sd);
    r.start_month = MONTH_W'(sm);
    r.start_year  = YEAR_W'(sy);
    r.end_day     = DAY_W'(ed);
    r.end_month   = MONTH_W'(em);
    r.end_year    = YEAR_W'(ey);
    return r;
  endfunction

  function automatic int unsigned pick_year();
    int unsigned edges[10] = '{1, 2, 4, 100, 400, 1900, 2000, 2100, 9998, 9999};
    if ($urandom_range(0, 9) == 0) begin
      return edges[$urandom_range(0, 9)];
    end
    return $urandom_range(1, 9999);
  endfunction

  function automatic logic [MONTH_W-1:0] bad_month();
    return ($urandom_range(0, 3) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
  endfunction

  function automatic logic [YEAR_W-1:0] bad_year();
    return ($urandom_range(0, 3) == 0) ? '0 : YEAR_W'($urandom_range(10000, 16383));
  endfunction

  // mostly short forward spans; a few long spans, swapped dates, bad fields, noise
  function automatic in_req_t random_request();
    int unsigned kind, sd, sm, sy, ed, em, ey, span;
    logic [63:0] noise;
    in_req_t     r;
    kind = $urandom_range(0, 99);
    sy = pick_year();
    sm = $urandom_range(1, 12);
    sd = $urandom_range(0, 31);
    if (kind < 2) begin
      span = $urandom_range(2, 100);
      ey = (sy + span > 9999) ? 9999 : sy + span;
      em = $urandom_range(1, 12);
      ed = $urandom_range(0, 31);
    end else begin
      ey = sy + (($urandom_range(0, 3) == 0) ? 1 : 0);
      if (ey > 9999) begin
        ey = 9999;
      end
      em = (ey == sy) ? $urandom_range(sm, 12) : $urandom_range(1, 12);
      ed = (ey == sy && em == sm) ? $urandom_range(sd, 31) : $urandom_range(0, 31);
    end
    r = make_request(sd, sm, sy, ed, em, ey);
    if (kind >= 2 && kind < 6) begin
      r = make_request(ed, em, ey, sd, sm, sy);
    end else if (kind >= 6 && kind < 10) begin
      span = $urandom_range(0, 3);
      if (span == 0) begin
        r.start_month = bad_month();
      end else if (span == 1) begin
        r.end_month = bad_month();
      end else if (span == 2) begin
        r.start_year = bad_year();
      end else begin
        r.end_year = bad_year();
      end
    end else if (kind >= 10 && kind < 14) begin
      noise = {$urandom, $urandom};
      r = noise[$bits(in_req_t)-1:0];
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input in_req_t r, input out_res_t result);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_weeks.push_back(result);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (expected_weeks.size() != 0);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_weeks.size() == 0) begin
        $error("unexpected result: week_count %0d bad_input %0d",
               out_data.week_count, out_data.bad_input);
        error_count++;
      end else begin
        oldest_weeks = expected_weeks.pop_front();
        if (out_data.week_count !== oldest_weeks.week_count) begin
          $error("week_count: expected %0d, got %0d",
                 oldest_weeks.week_count, out_data.week_count);
          error_count++;
        end
        if (out_data.bad_input !== oldest_weeks.bad_input) begin
          $error("bad_input: expected %0d, got %0d",
                 oldest_weeks.bad_input, out_data.bad_input);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_req_t  r;
    out_res_t result;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      r = make_request(DIRECTED[i][0], DIRECTED[i][1], DIRECTED[i][2],
                       DIRECTED[i][3], DIRECTED[i][4], DIRECTED[i][5]);
      if (DIRECTED[i][6] == UNTYPED) begin
        result = predict_weeks(r);
      end else begin
        result.week_count = COUNT_W'(DIRECTED[i][6]);
        result.bad_input  = (DIRECTED[i][7] != 0);
      end
      send_request(r, result);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 52;
        recv_idle_pct = 8;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = random_request();
        send_request(r, predict_weeks(r));
      end
      drain_requests();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_weeks.size() != 0) begin
      $error("%0d requests never answered", expected_weeks.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/cwc_pkg.sv
src/calendar_week_counter.sv
dv/tb_calendar_week_counter.sv
